// File: src/qru_pkg.sv
// ----------------------------------------------------------------------------
// qru_pkg: shared types and constants of the quaternion rotation unit
// Operation codes, operand selects, the step record that drives the shared
// multiply-accumulate unit, the product programme and the CORDIC angle table.
// ----------------------------------------------------------------------------
package qru_pkg;

  // Operation codes of an input transaction.
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_MUL    = 2'd1;
  localparam logic [1:0] OP_MATRIX = 2'd2;

  // Result kinds.
  localparam logic KIND_QUAT = 1'b0;
  localparam logic KIND_ROW  = 1'b1;

  // Operand selects: stored components, then operand components.
  localparam logic [2:0] SEL_W  = 3'd0;
  localparam logic [2:0] SEL_X  = 3'd1;
  localparam logic [2:0] SEL_Y  = 3'd2;
  localparam logic [2:0] SEL_Z  = 3'd3;
  localparam logic [2:0] SEL_OW = 3'd4;
  localparam logic [2:0] SEL_OX = 3'd5;
  localparam logic [2:0] SEL_OY = 3'd6;
  localparam logic [2:0] SEL_OZ = 3'd7;

  // Number of programme steps per matrix row and for the product.
  localparam int ROW_STEPS = 6;
  localparam int MUL_STEPS = 16;

  // CORDIC constants: angles in 1/128 degree, gain in Q2.30.
  localparam int CORDIC_TABLE_LEN = 24;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [16:0] HALF_TURN    = 17'sd23040;
  localparam logic signed [16:0] QUARTER_TURN = 17'sd11520;
  localparam logic signed [16:0] FULL_TURN    = 17'sd46080;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_CORDIC,
    S_LOAD,
    S_MAC,
    S_DRAIN,
    S_OUT,
    S_ROW3
  } qru_state_t;

  // One step of the shared multiply-accumulate unit.
  typedef struct packed {
    logic       valid;
    logic [2:0] a_sel;
    logic [2:0] b_sel;
    logic       neg;
    logic       dbl;
    logic       first;
    logic       init_one;
    logic       last;
    logic       row_end;
    logic       raw;
    logic [1:0] slot;
  } qru_step_t;

  function automatic qru_step_t qru_mk(input logic [2:0] a, input logic [2:0] b,
                                       input logic neg, input logic dbl,
                                       input logic first, input logic one,
                                       input logic last, input logic rend,
                                       input logic [1:0] slot);
    qru_step_t s;
    s.valid    = 1'b1;
    s.a_sel    = a;
    s.b_sel    = b;
    s.neg      = neg;
    s.dbl      = dbl;
    s.first    = first;
    s.init_one = one;
    s.last     = last;
    s.row_end  = rend;
    s.raw      = 1'b0;
    s.slot     = slot;
    return s;
  endfunction

  // Raw step for the axis-times-sine products of a load.
  function automatic qru_step_t qru_raw_step(input logic [1:0] slot);
    qru_step_t s;
    s         = '0;
    s.valid   = 1'b1;
    s.raw     = 1'b1;
    s.last    = 1'b1;
    s.slot    = slot;
    return s;
  endfunction

  // Product programme: Hamilton product, or the nine matrix entries.
  function automatic qru_step_t qru_prog(input logic is_mat, input logic [4:0] idx);
    qru_step_t s;
    s = '0;
    if (!is_mat) begin
      case (idx)
        5'd0:    s = qru_mk(SEL_W, SEL_OW, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 2'd0);
        5'd1:    s = qru_mk(SEL_X, SEL_OX, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0);
        5'd2:    s = qru_mk(SEL_Y, SEL_OY, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0);
        5'd3:    s = qru_mk(SEL_Z, SEL_OZ, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 2'd0);
        5'd4:    s = qru_mk(SEL_W, SEL_OX, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 2'd1);
        5'd5:    s = qru_mk(SEL_X, SEL_OW, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 2'd1);
        5'd6:    s = qru_mk(SEL_Y, SEL_OZ, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 2'd1);
        5'd7:    s = qru_mk(SEL_Z, SEL_OY, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 2'd1);
        5'd8:    s = qru_mk(SEL_W, SEL_OY, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 2'd2);
        5'd9:    s = qru_mk(SEL_Y, SEL_OW, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 2'd2);
        5'd10:   s = qru_mk(SEL_Z, SEL_OX, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 2'd2);
        5'd11:   s = qru_mk(SEL_X, SEL_OZ, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 2'd2);
        5'd12:   s = qru_mk(SEL_W, SEL_OZ, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 2'd3);
        5'd13:   s = qru_mk(SEL_Z, SEL_OW, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 2'd3);
        5'd14:   s = qru_mk(SEL_X, SEL_OY, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 2'd3);
        5'd15:   s = qru_mk(SEL_Y, SEL_OX, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 2'd3);
        default: s = '0;
      endcase
    end else begin
      case (idx)
        5'd0:    s = qru_mk(SEL_Y, SEL_Y, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 2'd0);
        5'd1:    s = qru_mk(SEL_Z, SEL_Z, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 2'd0);
        5'd2:    s = qru_mk(SEL_X, SEL_Y, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 2'd1);
        5'd3:    s = qru_mk(SEL_W, SEL_Z, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 2'd1);
        5'd4:    s = qru_mk(SEL_X, SEL_Z, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 2'd2);
        5'd5:    s = qru_mk(SEL_W, SEL_Y, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 2'd2);
        5'd6:    s = qru_mk(SEL_X, SEL_Y, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 2'd0);
        5'd7:    s = qru_mk(SEL_W, SEL_Z, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 2'd0);
        5'd8:    s = qru_mk(SEL_X, SEL_X, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 2'd1);
        5'd9:    s = qru_mk(SEL_Z, SEL_Z, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 2'd1);
        5'd10:   s = qru_mk(SEL_Y, SEL_Z, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 2'd2);
        5'd11:   s = qru_mk(SEL_W, SEL_X, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 2'd2);
        5'd12:   s = qru_mk(SEL_X, SEL_Z, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 2'd0);
        5'd13:   s = qru_mk(SEL_W, SEL_Y, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 2'd0);
        5'd14:   s = qru_mk(SEL_Y, SEL_Z, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 2'd1);
        5'd15:   s = qru_mk(SEL_W, SEL_X, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 2'd1);
        5'd16:   s = qru_mk(SEL_X, SEL_X, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 2'd2);
        5'd17:   s = qru_mk(SEL_Y, SEL_Y, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 2'd2);
        default: s = '0;
      endcase
    end
    return s;
  endfunction

  // Arctangent of 2^-i in 2^-23 degree units.
  function automatic logic signed [32:0] qru_atan(input logic [4:0] i);
    logic signed [32:0] v;
    case (i)
      5'd0:    v = 33'sd377487360;
      5'd1:    v = 33'sd222843801;
      5'd2:    v = 33'sd117744544;
      5'd3:    v = 33'sd59768969;
      5'd4:    v = 33'sd30000467;
      5'd5:    v = 33'sd15014858;
      5'd6:    v = 33'sd7509261;
      5'd7:    v = 33'sd3754860;
      5'd8:    v = 33'sd1877459;
      5'd9:    v = 33'sd938733;
      5'd10:   v = 33'sd469367;
      5'd11:   v = 33'sd234683;
      5'd12:   v = 33'sd117342;
      5'd13:   v = 33'sd58671;
      5'd14:   v = 33'sd29335;
      5'd15:   v = 33'sd14668;
      5'd16:   v = 33'sd7334;
      5'd17:   v = 33'sd3667;
      5'd18:   v = 33'sd1833;
      5'd19:   v = 33'sd917;
      5'd20:   v = 33'sd458;
      5'd21:   v = 33'sd229;
      5'd22:   v = 33'sd115;
      5'd23:   v = 33'sd57;
      default: v = 33'sd0;
    endcase
    return v;
  endfunction

endpackage

// File: src/qru_if.sv
// ----------------------------------------------------------------------------
// qru_in_if / qru_out_if: channels of the quaternion rotation unit
// Valid/ready channels that carry one input item and one result item.
// ----------------------------------------------------------------------------
interface qru_in_if #(parameter int CW = 16);
  logic                 valid;
  logic                 ready;
  logic [1:0]           op;
  logic signed [CW-1:0] axis_x;
  logic signed [CW-1:0] axis_y;
  logic signed [CW-1:0] axis_z;
  logic signed [15:0]   angle;
  logic signed [CW-1:0] other_w;
  logic signed [CW-1:0] other_x;
  logic signed [CW-1:0] other_y;
  logic signed [CW-1:0] other_z;

  modport source (output valid, op, axis_x, axis_y, axis_z, angle,
                  other_w, other_x, other_y, other_z, input ready);
  modport sink (input valid, op, axis_x, axis_y, axis_z, angle,
                other_w, other_x, other_y, other_z, output ready);
endinterface

interface qru_out_if #(parameter int CW = 16);
  logic                 valid;
  logic                 ready;
  logic                 result_kind;
  logic [1:0]           row_index;
  logic signed [CW-1:0] value_0;
  logic signed [CW-1:0] value_1;
  logic signed [CW-1:0] value_2;
  logic signed [CW-1:0] value_3;
  logic                 last_row;

  modport source (output valid, result_kind, row_index, value_0, value_1,
                  value_2, value_3, last_row, input ready);
  modport sink (input valid, result_kind, row_index, value_0, value_1,
                value_2, value_3, last_row, output ready);
endinterface

// File: src/quaternion_rotation_unit.sv
// ----------------------------------------------------------------------------
// One transaction at a time. The CORDIC loop sets the load time, the single
// multiplier the others.
// Reset (synchronous, active low) sets the quaternion to identity.
// ----------------------------------------------------------------------------
// quaternion_rotation_unit: quaternion arithmetic under a small sequencer
// Keeps one quaternion; loads it from axis and angle, multiplies it by an
// operand or emits its rotation matrix row by row.
// ----------------------------------------------------------------------------
module quaternion_rotation_unit import qru_pkg::*; #(
  parameter int COMP_WIDTH   = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  qru_in_if.sink   in_chan,
  qru_out_if.source out_chan
);

  localparam int CW  = COMP_WIDTH;
  localparam int F   = CW - 2;
  localparam int SHC = 32 - CW;
  localparam logic signed [34:0] RND_C = (SHC == 0) ? 35'sd0 :
                                         (35'sd1 <<< ((SHC == 0) ? 0 : SHC - 1));
  localparam logic signed [34:0] HI_C  = (35'sd1 <<< (CW - 1)) - 35'sd1;
  localparam logic signed [34:0] LO_C  = -HI_C - 35'sd1;
  localparam logic signed [CW-1:0] ONE_Q = CW'(1) <<< F;

  qru_state_t state_r, state_nxt;
  logic [1:0] op_r, row_r, cnt_r;
  logic [4:0] step_r;
  logic signed [CW-1:0] ax_r, ay_r, az_r, ow_r, ox_r, oy_r, oz_r;
  logic signed [CW-1:0] qw_r, qx_r, qy_r, qz_r;
  logic signed [CW-1:0] val_r [4];

  logic                 out_valid_r, out_kind_r, out_last_r;
  logic [1:0]           out_row_r;
  logic signed [CW-1:0] out_v0_r, out_v1_r, out_v2_r, out_v3_r;

  logic      in_take, out_free, out_load, cordic_start, cordic_done, is_mat;
  qru_step_t issue;
  logic signed [CW-1:0] a_op, b_q;
  logic signed [31:0]   b_op;
  logic signed [33:0]   cos_v, sin_v;
  logic signed [34:0]   cos_rnd;
  logic signed [CW-1:0] cos_sat;
  logic                 fin_valid;
  logic [1:0]           fin_slot;
  logic signed [CW-1:0] fin_value;

  function automatic logic signed [CW-1:0] pick(input logic [2:0] sel,
      input logic signed [CW-1:0] w, input logic signed [CW-1:0] x,
      input logic signed [CW-1:0] y, input logic signed [CW-1:0] z,
      input logic signed [CW-1:0] ow, input logic signed [CW-1:0] ox,
      input logic signed [CW-1:0] oy, input logic signed [CW-1:0] oz);
    logic signed [CW-1:0] r;
    case (sel)
      SEL_W:   r = w;
      SEL_X:   r = x;
      SEL_Y:   r = y;
      SEL_Z:   r = z;
      SEL_OW:  r = ow;
      SEL_OX:  r = ox;
      SEL_OY:  r = oy;
      default: r = oz;
    endcase
    return r;
  endfunction

  assign is_mat   = (op_r == OP_MATRIX);
  assign out_free = !out_valid_r || out_chan.ready;
  assign in_take  = in_chan.valid && in_chan.ready;

  // Sequencer outputs.
  always_comb begin
    in_chan.ready = (state_r == S_IDLE);
    cordic_start  = in_chan.valid && (state_r == S_IDLE) && (in_chan.op == OP_LOAD);
    issue         = '0;
    out_load      = 1'b0;
    case (state_r)
      S_LOAD:  issue = qru_raw_step(cnt_r + 2'd1);
      S_MAC:   issue = qru_prog(is_mat, step_r);
      S_OUT:   out_load = out_free;
      S_ROW3:  out_load = out_free;
      default: issue = '0;
    endcase
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          case (in_chan.op)
            OP_LOAD:   state_nxt = S_CORDIC;
            OP_MUL:    state_nxt = S_MAC;
            OP_MATRIX: state_nxt = S_MAC;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_CORDIC: if (cordic_done) state_nxt = S_LOAD;
      S_LOAD:   if (cnt_r == 2'd2) state_nxt = S_DRAIN;
      S_MAC:    if (issue.row_end) state_nxt = S_DRAIN;
      S_DRAIN:  state_nxt = S_OUT;
      S_OUT: begin
        if (out_free) begin
          if (!is_mat) state_nxt = S_IDLE;
          else if (row_r == 2'd2) state_nxt = S_ROW3;
          else state_nxt = S_MAC;
        end
      end
      S_ROW3:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    if (issue.raw) begin
      case (cnt_r)
        2'd0:    a_op = ax_r;
        2'd1:    a_op = ay_r;
        default: a_op = az_r;
      endcase
      b_q  = '0;
      b_op = 32'(sin_v);
    end else begin
      a_op = pick(issue.a_sel, qw_r, qx_r, qy_r, qz_r, ow_r, ox_r, oy_r, oz_r);
      b_q  = pick(issue.b_sel, qw_r, qx_r, qy_r, qz_r, ow_r, ox_r, oy_r, oz_r);
      b_op = 32'(b_q);
    end
  end

  // Cosine rounded to the component format.
  always_comb begin
    cos_rnd = (35'(cos_v) + RND_C) >>> SHC;
    if (cos_rnd > HI_C) cos_sat = HI_C[CW-1:0];
    else if (cos_rnd < LO_C) cos_sat = LO_C[CW-1:0];
    else cos_sat = cos_rnd[CW-1:0];
  end

  // The CORDIC starts on the accepting edge, so it takes the angle straight
  // from the channel.
  qru_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (cordic_start),
    .angle_i (in_chan.angle),
    .done_o  (cordic_done),
    .cos_o   (cos_v),
    .sin_o   (sin_v)
  );

  qru_mac #(.CW(CW)) u_mac (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_i      (issue),
    .a_i         (a_op),
    .b_i         (b_op),
    .fin_valid_o (fin_valid),
    .fin_slot_o  (fin_slot),
    .fin_value_o (fin_value)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_LOAD;
      row_r       <= '0;
      cnt_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      qw_r        <= ONE_Q;
      qx_r        <= '0;
      qy_r        <= '0;
      qz_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_take) begin
        op_r   <= in_chan.op;
        row_r  <= '0;
        cnt_r  <= '0;
        step_r <= '0;
      end
      if (state_r == S_LOAD) cnt_r <= cnt_r + 2'd1;
      if (state_r == S_MAC) step_r <= step_r + 5'd1;
      if (out_load && (state_r == S_OUT) && is_mat) row_r <= row_r + 2'd1;
      if (out_load && (state_r == S_OUT) && (op_r == OP_LOAD)) begin
        qw_r <= val_r[0];
        qx_r <= val_r[1];
        qy_r <= val_r[2];
        qz_r <= val_r[3];
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_chan.ready) out_valid_r <= 1'b0;
    end
  end

  // Operand capture and result slots.
  always_ff @(posedge clk) begin
    if (in_take) begin
      ax_r    <= in_chan.axis_x;
      ay_r    <= in_chan.axis_y;
      az_r    <= in_chan.axis_z;
      ow_r    <= in_chan.other_w;
      ox_r    <= in_chan.other_x;
      oy_r    <= in_chan.other_y;
      oz_r    <= in_chan.other_z;
    end
    if ((state_r == S_CORDIC) && cordic_done) val_r[0] <= cos_sat;
    if (fin_valid) val_r[fin_slot] <= fin_value;
  end

  // Output register: one transaction per row or quaternion.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind_r <= is_mat ? KIND_ROW : KIND_QUAT;
      if (state_r == S_ROW3) begin
        out_row_r  <= 2'd3;
        out_v0_r   <= '0;
        out_v1_r   <= '0;
        out_v2_r   <= '0;
        out_v3_r   <= ONE_Q;
        out_last_r <= 1'b1;
      end else begin
        out_row_r  <= is_mat ? row_r : 2'd0;
        out_v0_r   <= val_r[0];
        out_v1_r   <= val_r[1];
        out_v2_r   <= val_r[2];
        out_v3_r   <= is_mat ? '0 : val_r[3];
        out_last_r <= !is_mat;
      end
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.result_kind = out_kind_r;
  assign out_chan.row_index   = out_row_r;
  assign out_chan.value_0     = out_v0_r;
  assign out_chan.value_1     = out_v1_r;
  assign out_chan.value_2     = out_v2_r;
  assign out_chan.value_3     = out_v3_r;
  assign out_chan.last_row    = out_last_r;

endmodule

// File: src/qru_cordic.sv
// ----------------------------------------------------------------------------
// qru_cordic: iterative half-angle sine and cosine
// Wraps the half angle into a quarter turn and runs one rotation-mode CORDIC
// step per cycle on a single shift-and-add datapath.
// ----------------------------------------------------------------------------
module qru_cordic import qru_pkg::*; #(
  parameter int STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start_i,
  input  logic signed [15:0] angle_i,
  output logic               done_o,
  output logic signed [33:0] cos_o,
  output logic signed [33:0] sin_o
);

  localparam int NS = (STEPS > CORDIC_TABLE_LEN) ? CORDIC_TABLE_LEN : STEPS;
  localparam int IW = $clog2(NS + 1);

  logic              busy_r;
  logic [IW-1:0]     cnt_r;
  logic signed [33:0] x_r, y_r;
  logic signed [32:0] z_r;
  logic              neg_r;

  logic signed [16:0] h_wrap, h_fold;
  logic               neg_nxt;
  logic signed [33:0] x_sh, y_sh;
  logic signed [32:0] atan_v;

  // Wrap into a half turn either way, then fold into a quarter turn.
  always_comb begin
    h_wrap = 17'(angle_i);
    if (h_wrap > HALF_TURN) h_wrap = h_wrap - FULL_TURN;
    if (h_wrap < -HALF_TURN) h_wrap = h_wrap + FULL_TURN;
    neg_nxt = 1'b0;
    h_fold  = h_wrap;
    if (h_wrap > QUARTER_TURN) begin
      h_fold  = h_wrap - HALF_TURN;
      neg_nxt = 1'b1;
    end else if (h_wrap < -QUARTER_TURN) begin
      h_fold  = h_wrap + HALF_TURN;
      neg_nxt = 1'b1;
    end
  end

  // Shared shifter and table lookup for the current step.
  assign x_sh   = x_r >>> cnt_r;
  assign y_sh   = y_r >>> cnt_r;
  assign atan_v = qru_atan(5'(cnt_r));

  // Control registers of the iteration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start_i) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      if (cnt_r == IW'(NS)) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // Datapath: one micro-rotation per cycle.
  always_ff @(posedge clk) begin
    if (start_i) begin
      x_r   <= CORDIC_GAIN;
      y_r   <= '0;
      z_r   <= 33'(h_fold) <<< 16;
      neg_r <= neg_nxt;
    end else if (busy_r && (cnt_r != IW'(NS))) begin
      if (z_r >= 0) begin
        x_r <= x_r - y_sh;
        y_r <= y_r + x_sh;
        z_r <= z_r - atan_v;
      end else begin
        x_r <= x_r + y_sh;
        y_r <= y_r - x_sh;
        z_r <= z_r + atan_v;
      end
    end
  end

  assign done_o = busy_r && (cnt_r == IW'(NS));
  assign cos_o  = neg_r ? -x_r : x_r;
  assign sin_o  = neg_r ? -y_r : y_r;

endmodule

// File: src/qru_mac.sv
// ----------------------------------------------------------------------------
// qru_mac: shared multiply-accumulate unit
// One registered multiplier followed by an accumulator with rounding and
// saturation to the component range.
// ----------------------------------------------------------------------------
module qru_mac import qru_pkg::*; #(
  parameter int CW = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  qru_step_t            step_i,
  input  logic signed [CW-1:0] a_i,
  input  logic signed [31:0]   b_i,
  output logic                 fin_valid_o,
  output logic [1:0]           fin_slot_o,
  output logic signed [CW-1:0] fin_value_o
);

  localparam int PW = CW + 32;
  localparam int AW = PW + 2;
  localparam int F  = CW - 2;
  localparam int RS = CW - 4;
  localparam logic signed [AW-1:0] ONE    = AW'(1) <<< (2 * F - 2);
  localparam logic signed [AW-1:0] RND_A  = AW'(1) <<< (RS - 1);
  localparam logic signed [AW-1:0] HI_A   = (AW'(1) <<< (CW - 1)) - AW'(1);
  localparam logic signed [AW-1:0] LO_A   = -HI_A - AW'(1);
  localparam logic signed [PW:0]   RND_R  = (PW + 1)'(1) <<< 29;
  localparam logic signed [PW:0]   HI_R   = ((PW + 1)'(1) <<< (CW - 1)) - (PW + 1)'(1);
  localparam logic signed [PW:0]   LO_R   = -HI_R - (PW + 1)'(1);

  logic signed [PW-1:0] prod_r;
  qru_step_t            ctl_r;
  logic signed [AW-1:0] acc_r;

  logic signed [AW-1:0] term, base, sum, rnd_a;
  logic signed [PW:0]   rnd_r;
  logic signed [CW-1:0] sat_a, sat_r;

  // Multiplier stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= step_i;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= PW'(a_i) * PW'(b_i);
  end

  // Accumulate the floored product, then round and saturate; a raw step rounds and saturates the product alone.
  always_comb begin
    term = AW'(prod_r >>> 2);
    if (ctl_r.dbl) term = term <<< 1;
    if (ctl_r.first) begin
      base = ctl_r.init_one ? ONE : '0;
    end else begin
      base = acc_r;
    end
    sum   = ctl_r.neg ? (base - term) : (base + term);
    rnd_a = (sum + RND_A) >>> RS;
    if (rnd_a > HI_A) sat_a = HI_A[CW-1:0];
    else if (rnd_a < LO_A) sat_a = LO_A[CW-1:0];
    else sat_a = rnd_a[CW-1:0];
    rnd_r = ((PW + 1)'(prod_r) + RND_R) >>> 30;
    if (rnd_r > HI_R) sat_r = HI_R[CW-1:0];
    else if (rnd_r < LO_R) sat_r = LO_R[CW-1:0];
    else sat_r = rnd_r[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctl_r.valid && !ctl_r.raw) acc_r <= sum;
  end

  assign fin_valid_o = ctl_r.valid && (ctl_r.last || ctl_r.raw);
  assign fin_slot_o  = ctl_r.slot;
  assign fin_value_o = ctl_r.raw ? sat_r : sat_a;

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the quaternion rotation unit
// Drives loads, products, matrix requests and unused op codes through the
// input channel, and stalls the result channel at random. An own model of the
// unit predicts every result item, and the checker compares each field with it.
// ----------------------------------------------------------------------------
module tb_top;
  import qru_pkg::*;

  localparam int CW = 16;
  localparam int FR = CW - 2;
  localparam int N_STEPS = 16;
  localparam int N_RANDOM = 320;
  localparam longint MAX_CYCLES = 400000;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] ax, ay, az, ang, ow, ox, oy, oz;
  } qru_req_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  row;
    logic [15:0] v0, v1, v2, v3;
    logic        last;
  } qru_res_t;

  // Expected results in order, and the quaternion they derive from.
  class quat_scoreboard;
    longint qw, qx, qy, qz;
    qru_res_t pending[$];
    int mismatches;

    function new();
      qw = 64'sd1 <<< FR;
      qx = 0;
      qy = 0;
      qz = 0;
      mismatches = 0;
    endfunction

    function longint fl(longint v, int s);
      return v >>> s;
    endfunction

    function longint rsat(longint v, int s);
      longint r;
      r = (s == 0) ? v : ((v + (64'sd1 <<< (s - 1))) >>> s);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r;
    endfunction

    function longint mp(longint a, longint b);
      return fl(a * b, 2);
    endfunction

    function longint rp(longint v);
      return rsat(v, FR - 2);
    endfunction

    function void push(logic k, logic [1:0] r, longint a, longint b, longint c,
                       longint d, logic l);
      qru_res_t e;
      e.kind = k;
      e.row = r;
      e.v0 = a[15:0];
      e.v1 = b[15:0];
      e.v2 = c[15:0];
      e.v3 = d[15:0];
      e.last = l;
      pending.push_back(e);
    endfunction

    // Half-angle cosine and sine by rotation-mode CORDIC, Q2.30.
    function void half_sin_cos(longint h, output longint c, output longint s);
      longint x, y, z, nx;
      bit neg;
      neg = 0;
      x = 652032874;
      y = 0;
      if (h > 23040) h -= 46080;
      if (h < -23040) h += 46080;
      if (h > 11520) begin
        h -= 23040;
        neg = 1;
      end else if (h < -11520) begin
        h += 23040;
        neg = 1;
      end
      z = h * 65536;
      for (int i = 0; i < N_STEPS; i++) begin
        if (z >= 0) begin
          nx = x - fl(y, i);
          y = y + fl(x, i);
          z -= longint'(qru_atan(i[4:0]));
        end else begin
          nx = x + fl(y, i);
          y = y - fl(x, i);
          z += longint'(qru_atan(i[4:0]));
        end
        x = nx;
      end
      c = neg ? -x : x;
      s = neg ? -y : y;
    endfunction

    // Note an accepted input transaction and queue what it must produce.
    function void note_request(qru_req_t q);
      longint c, s, w, x, y, z, a, b, d, e, one;
      w = qw;
      x = qx;
      y = qy;
      z = qz;
      if (q.op == OP_LOAD) begin
        half_sin_cos(longint'($signed(q.ang)), c, s);
        qw = rsat(c, 30 - FR);
        qx = rsat(longint'($signed(q.ax)) * s, 30);
        qy = rsat(longint'($signed(q.ay)) * s, 30);
        qz = rsat(longint'($signed(q.az)) * s, 30);
        push(KIND_QUAT, 2'd0, qw, qx, qy, qz, 1'b1);
      end else if (q.op == OP_MUL) begin
        a = $signed(q.ow);
        b = $signed(q.ox);
        d = $signed(q.oy);
        e = $signed(q.oz);
        push(KIND_QUAT, 2'd0,
             rp(mp(w, a) - mp(x, b) - mp(y, d) - mp(z, e)),
             rp(mp(w, b) + mp(x, a) + mp(y, e) - mp(z, d)),
             rp(mp(w, d) + mp(y, a) + mp(z, b) - mp(x, e)),
             rp(mp(w, e) + mp(z, a) + mp(x, d) - mp(y, b)), 1'b1);
      end else if (q.op == OP_MATRIX) begin
        one = 64'sd1 <<< (2 * FR - 2);
        push(KIND_ROW, 2'd0, rp(one - 2 * (mp(y, y) + mp(z, z))),
             rp(2 * (mp(x, y) - mp(w, z))), rp(2 * (mp(x, z) + mp(w, y))), 0, 1'b0);
        push(KIND_ROW, 2'd1, rp(2 * (mp(x, y) + mp(w, z))),
             rp(one - 2 * (mp(x, x) + mp(z, z))), rp(2 * (mp(y, z) - mp(w, x))), 0, 1'b0);
        push(KIND_ROW, 2'd2, rp(2 * (mp(x, z) - mp(w, y))),
             rp(2 * (mp(y, z) + mp(w, x))), rp(one - 2 * (mp(x, x) + mp(y, y))), 0, 1'b0);
        push(KIND_ROW, 2'd3, 0, 0, 0, 64'sd1 <<< FR, 1'b1);
      end
    endfunction

    // Compare an accepted result transaction with the oldest expectation.
    function void check_result(qru_res_t got);
      qru_res_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"Mismatch: expected kind %0d row %0d %0d %0d %0d %0d last %0d,",
                    " got kind %0d row %0d %0d %0d %0d %0d last %0d"},
                   exp_r.kind, exp_r.row, $signed(exp_r.v0), $signed(exp_r.v1),
                   $signed(exp_r.v2), $signed(exp_r.v3), exp_r.last,
                   got.kind, got.row, $signed(got.v0), $signed(got.v1),
                   $signed(got.v2), $signed(got.v3), got.last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  longint cycles = 0;
  bit hold_off = 1'b0;
  quat_scoreboard board = new();

  qru_in_if #(.CW(CW)) in_chan ();
  qru_out_if #(.CW(CW)) out_chan ();

  quaternion_rotation_unit #(.COMP_WIDTH(CW), .CORDIC_STEPS(N_STEPS)) DUT (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan.sink), .out_chan(out_chan.source)
  );

  always #5 clk = ~clk;

  initial begin
    in_chan.valid = 1'b0;
    {in_chan.op, in_chan.axis_x, in_chan.axis_y, in_chan.axis_z, in_chan.angle,
     in_chan.other_w, in_chan.other_x, in_chan.other_y, in_chan.other_z} = '0;
    out_chan.ready = 1'b0;
  end

  // Cycle count and timeout.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("FAIL quaternion_rotation_unit");
      $finish;
    end
  end

  // Accepted transactions on both channels feed the scoreboard.
  always @(posedge clk) begin
    if (rst_n && in_chan.valid && in_chan.ready)
      board.note_request({in_chan.op, in_chan.axis_x, in_chan.axis_y, in_chan.axis_z,
                          in_chan.angle, in_chan.other_w, in_chan.other_x,
                          in_chan.other_y, in_chan.other_z});
    if (rst_n && out_chan.valid && out_chan.ready)
      board.check_result({out_chan.result_kind, out_chan.row_index, out_chan.value_0,
                          out_chan.value_1, out_chan.value_2, out_chan.value_3,
                          out_chan.last_row});
  end

  // Receiver: random stalls, with one long hold-off on request.
  initial begin : receiver
    int gap;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off) begin
        out_chan.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (cycles % 3000 < 600) gap = 0;
      if (gap > 0) begin
        out_chan.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      @(posedge clk iff out_chan.valid);
    end
  end

  // Offer one transaction after a random gap, or none if no_gap is set, and wait for its acceptance.
  task automatic send_request(qru_req_t q, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 16);
    if (!no_gap && $urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    {in_chan.op, in_chan.axis_x, in_chan.axis_y, in_chan.axis_z, in_chan.angle,
     in_chan.other_w, in_chan.other_x, in_chan.other_y, in_chan.other_z} <= q;
    @(posedge clk iff in_chan.ready);
  endtask

  function automatic logic [15:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h4000;
      3: return 16'hc000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic qru_req_t rand_request();
    qru_req_t q;
    q = {2'($urandom_range(0, 2)), rand_val(), rand_val(), rand_val(), 16'($urandom),
         rand_val(), rand_val(), rand_val(), rand_val()};
    // Mostly small, well-formed axes so that results stay in range.
    if (q.op == OP_LOAD && $urandom_range(0, 2) != 0) begin
      q.ax = 16'($signed($urandom_range(0, 32768)) - 16384);
      q.ay = 16'($signed($urandom_range(0, 32768)) - 16384);
      q.az = 16'($signed($urandom_range(0, 32768)) - 16384);
    end
    if ($urandom_range(0, 30) == 0) q.op = 2'd3;
    return q;
  endfunction

  // Stimulus: directed cases, then random, then drain and verdict.
  initial begin : stimulus
    qru_req_t q;
    int wait_n;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Identity matrix and a product with the identity, then the angle extremes and wrap points.
    send_request({OP_MATRIX, 128'h0}, 1'b0);
    send_request({OP_MUL, 64'h0, 16'h4000, 16'h0, 16'h0, 16'h0}, 1'b0);
    for (int i = 0; i < 8; i++) begin
      logic [15:0] ang;
      case (i)
        0: ang = 16'h0000;
        1: ang = 16'h7fff;
        2: ang = 16'h8000;
        3: ang = 16'd11520;
        4: ang = 16'd11521;
        5: ang = -16'sd11521;
        6: ang = 16'd23040;
        default: ang = -16'sd23041;
      endcase
      send_request({OP_LOAD, 16'h7fff, 16'h8000, 16'h4000, ang, 64'h0}, 1'b0);
      send_request({OP_MATRIX, 128'h0}, 1'b0);
    end
    // A load, then products with extreme operands, saturating, an unused op code and a matrix.
    send_request({OP_LOAD, 16'h4000, 16'h4000, 16'h4000, 16'd5760, 64'h0}, 1'b0);
    send_request({OP_MUL, 48'h0, 16'h0, 16'h8000, 16'h8000, 16'h8000, 16'h8000}, 1'b0);
    send_request({OP_MUL, 48'h0, 16'h0, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff}, 1'b0);
    send_request({2'd3, {8{16'hffff}}}, 1'b0);
    send_request({OP_MATRIX, 128'h0}, 1'b0);
    // Long receiver hold-off while the sender keeps offering.
    hold_off = 1'b1;
    for (int i = 0; i < 20; i++) send_request(rand_request(), 1'b1);
    for (int i = 0; i < N_RANDOM; i++) send_request(rand_request(), 1'b0);
    in_chan.valid <= 1'b0;
    @(posedge clk iff board.pending.size() == 0);
    repeat (60) @(posedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("PASS quaternion_rotation_unit");
    else
      $display("FAIL quaternion_rotation_unit");
    $finish;
  end
endmodule

// File: quaternion_rotation_unit.f
src/qru_pkg.sv
src/qru_if.sv
src/qru_cordic.sv
src/qru_mac.sv
src/quaternion_rotation_unit.sv
sim/tb_top.sv
